// File: hdl/compass_heading_with_calibration_unit_macros.svh
// Shared assertion helpers for the compass heading unit.
`ifndef COMPASS_HEADING_WITH_CALIBRATION_UNIT_MACROS_SVH
`define COMPASS_HEADING_WITH_CALIBRATION_UNIT_MACROS_SVH

// Expression must hold at every edge out of reset.
`define CCH_ASSERT_HOLD(name, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("invariant violated");

// Consequent must hold at the same edge as the antecedent.
`define CCH_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication violated");

`endif

// File: hdl/cch_pkg.sv
`default_nettype none
package cch_pkg;
	localparam int SAMPLE_W  = 16;
	localparam int DEG_W     = 9;
	localparam int NUM_W     = 17;
	localparam int VEC_W     = 35;
	localparam int VEC_SHIFT = 20;
	localparam int QBITS     = 16;
	localparam int ANGLE_W   = 32;
	localparam int PROD_W    = ANGLE_W + 9;
	localparam int ATAN_N    = 24;
	localparam int REG_IDX_W = 2;
	localparam int MID_DEPTH = 4;
	localparam int MID_CW    = 3;

	localparam logic [REG_IDX_W-1:0] REG_X_UPPER = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_X_LOWER = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_Y_UPPER = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_Y_LOWER = 2'd3;

	localparam logic [SAMPLE_W-1:0] NORM_MAX  = 16'h7FFF;
	localparam logic [SAMPLE_W-1:0] NORM_MIN  = 16'h8000;
	localparam logic [ANGLE_W-1:0]  HALF_TURN = 32'h8000_0000;
	localparam logic [DEG_W-1:0]    FULL_DEG  = 9'd360;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] x_sample;
		logic signed [SAMPLE_W-1:0] y_sample;
	} cch_in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] x_norm;
		logic signed [SAMPLE_W-1:0] y_norm;
		logic [DEG_W-1:0]           heading_deg;
		logic                       range_error;
	} cch_out_t;

	// one classified sample, front to back
	typedef struct packed {
		logic                    range_err;
		logic                    neg_x;
		logic                    neg_y;
		logic [NUM_W-1:0]        mag_x;
		logic [NUM_W-1:0]        mag_y;
		logic signed [VEC_W-1:0] vec_x;
		logic signed [VEC_W-1:0] vec_y;
	} cch_work_t;

	// calibration spans |upper - lower|
	typedef struct packed {
		logic [SAMPLE_W-1:0] span_x;
		logic [SAMPLE_W-1:0] span_y;
	} cch_cal_t;

	function automatic int cordic_len(input int steps);
		return (steps < ATAN_N) ? steps : ATAN_N;
	endfunction

	function automatic int pipe_len(input int steps);
		return (cordic_len(steps) > QBITS) ? cordic_len(steps) : QBITS;
	endfunction

	// atan(2^-i), full circle = 2^32
	function automatic logic [ANGLE_W-1:0] atan_angle(input int unsigned idx);
		logic [ANGLE_W-1:0] a;
		case (idx)
			0:  a = 32'h20000000;
			1:  a = 32'h12E4051E;
			2:  a = 32'h09FB385B;
			3:  a = 32'h051111D4;
			4:  a = 32'h028B0D43;
			5:  a = 32'h0145D7E1;
			6:  a = 32'h00A2F61E;
			7:  a = 32'h00517C55;
			8:  a = 32'h0028BE53;
			9:  a = 32'h00145F2F;
			10: a = 32'h000A2F98;
			11: a = 32'h000517CC;
			12: a = 32'h00028BE6;
			13: a = 32'h000145F3;
			14: a = 32'h0000A2FA;
			15: a = 32'h0000517D;
			16: a = 32'h000028BE;
			17: a = 32'h0000145F;
			18: a = 32'h00000A30;
			19: a = 32'h00000518;
			20: a = 32'h0000028C;
			21: a = 32'h00000146;
			22: a = 32'h000000A3;
			23: a = 32'h00000051;
			default: a = '0;
		endcase
		return a;
	endfunction
endpackage
`default_nettype wire

// File: hdl/cch_fifo.sv
`default_nettype none
`include "compass_heading_with_calibration_unit_macros.svh"
module cch_fifo #(
	parameter int W = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [W-1:0]               din,
	input  logic                       pop,
	output logic [W-1:0]               dout,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	logic [W-1:0]  mem [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + AW'(1);
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

	assign dout  = mem[rd_q];
	assign empty = (count_q == '0);
	assign count = count_q;

	`CCH_ASSERT_IMPL(a_fifo_no_underflow, pop, !empty)
	`CCH_ASSERT_IMPL(a_fifo_no_overflow, push && !pop, count_q != CW'(DEPTH))
	`CCH_ASSERT_HOLD(a_fifo_count_bound, count_q <= CW'(DEPTH))
endmodule
`default_nettype wire

// File: hdl/cch_front.sv
`default_nettype none
module cch_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [cch_pkg::REG_IDX_W-1:0]    wr_idx,
	input  logic [cch_pkg::SAMPLE_W-1:0]     wr_data,
	input  logic                             push,
	input  cch_pkg::cch_in_t                 item,
	output logic                             full,
	input  logic [cch_pkg::MID_CW-1:0]       mid_count,
	output logic                             mid_push,
	output cch_pkg::cch_work_t               mid_data,
	output cch_pkg::cch_cal_t                cal
);
	import cch_pkg::*;

	localparam logic [MID_CW:0] MID_FULL = (MID_CW+1)'(MID_DEPTH);

	logic signed [SAMPLE_W-1:0] x_upper_q, x_lower_q, y_upper_q, y_lower_q;
	logic signed [SAMPLE_W:0]   sum_x, sum_y, dif_x, dif_y;
	logic [SAMPLE_W-1:0]        span_x, span_y;
	logic                       accept;
	logic signed [NUM_W:0]      nx_c, ny_c;
	logic                       valid_s1, valid_s2;
	logic signed [NUM_W:0]      nx_s1, ny_s1;
	logic signed [VEC_W-1:0]    prod_x, prod_y;
	cch_work_t                  work_c, work_s2;
	logic [MID_CW:0]            occ;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_upper_q <= '0;
			x_lower_q <= '0;
			y_upper_q <= '0;
			y_lower_q <= '0;
		end else if (wr_en) begin
			case (wr_idx)
				REG_X_UPPER: x_upper_q <= wr_data;
				REG_X_LOWER: x_lower_q <= wr_data;
				REG_Y_UPPER: y_upper_q <= wr_data;
				REG_Y_LOWER: y_lower_q <= wr_data;
				default:     x_upper_q <= x_upper_q;
			endcase
		end
	end

	always_comb begin
		sum_x  = {x_upper_q[SAMPLE_W-1], x_upper_q} + {x_lower_q[SAMPLE_W-1], x_lower_q};
		sum_y  = {y_upper_q[SAMPLE_W-1], y_upper_q} + {y_lower_q[SAMPLE_W-1], y_lower_q};
		dif_x  = {x_upper_q[SAMPLE_W-1], x_upper_q} - {x_lower_q[SAMPLE_W-1], x_lower_q};
		dif_y  = {y_upper_q[SAMPLE_W-1], y_upper_q} - {y_lower_q[SAMPLE_W-1], y_lower_q};
		span_x = dif_x[SAMPLE_W] ? SAMPLE_W'(-dif_x) : dif_x[SAMPLE_W-1:0];
		span_y = dif_y[SAMPLE_W] ? SAMPLE_W'(-dif_y) : dif_y[SAMPLE_W-1:0];
	end

	assign cal.span_x = span_x;
	assign cal.span_y = span_y;

	// credit check: queue entries plus beats still in the two stages
	assign occ    = {1'b0, mid_count} + {{MID_CW{1'b0}}, valid_s1}
		+ {{MID_CW{1'b0}}, valid_s2};
	assign full   = (occ >= MID_FULL);
	assign accept = push && !full;

	// centered numerator 2*s - upper - lower
	assign nx_c = {item.x_sample[SAMPLE_W-1], item.x_sample, 1'b0}
		- {sum_x[SAMPLE_W], sum_x};
	assign ny_c = {item.y_sample[SAMPLE_W-1], item.y_sample, 1'b0}
		- {sum_y[SAMPLE_W], sum_y};

	always_comb begin
		prod_x = nx_s1 * $signed({1'b0, span_y});
		prod_y = ny_s1 * $signed({1'b0, span_x});
		work_c.range_err = (dif_x == '0) || (dif_y == '0);
		work_c.neg_x     = nx_s1[NUM_W] ^ dif_x[SAMPLE_W];
		work_c.neg_y     = ny_s1[NUM_W] ^ dif_y[SAMPLE_W];
		work_c.mag_x     = nx_s1[NUM_W] ? NUM_W'(-nx_s1) : nx_s1[NUM_W-1:0];
		work_c.mag_y     = ny_s1[NUM_W] ? NUM_W'(-ny_s1) : ny_s1[NUM_W-1:0];
		work_c.vec_x     = dif_x[SAMPLE_W] ? -prod_x : prod_x;
		work_c.vec_y     = dif_y[SAMPLE_W] ? -prod_y : prod_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		nx_s1   <= nx_c;
		ny_s1   <= ny_c;
		work_s2 <= work_c;
	end

	assign mid_push = valid_s2;
	assign mid_data = work_s2;
endmodule
`default_nettype wire

// File: hdl/cch_back.sv
`default_nettype none
`include "compass_heading_with_calibration_unit_macros.svh"
module cch_back #(
	parameter int CORDIC_STEPS = 16,
	parameter int FRAC_BITS = 14,
	parameter int OUT_DEPTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                mid_empty,
	input  cch_pkg::cch_work_t  mid_data,
	output logic                mid_pop,
	input  cch_pkg::cch_cal_t   cal,
	input  logic                res_pop,
	output logic                res_push,
	output cch_pkg::cch_out_t   res_data
);
	import cch_pkg::*;

	localparam int STEPS = cordic_len(CORDIC_STEPS);
	localparam int DEPTH = pipe_len(CORDIC_STEPS);
	localparam int RW    = NUM_W + FRAC_BITS + 2;
	localparam int DW    = RW + QBITS + 2;
	localparam int CW    = VEC_W + VEC_SHIFT + 3;
	localparam int HW    = $clog2(OUT_DEPTH+1);

	typedef struct packed {
		logic                     err;
		logic                     zero;
		logic                     neg_x;
		logic                     neg_y;
		logic                     ovf_x;
		logic                     ovf_y;
		logic [RW-1:0]            rem_x;
		logic [RW-1:0]            rem_y;
		logic [QBITS-1:0]         q_x;
		logic [QBITS-1:0]         q_y;
		logic signed [CW-1:0]     cx;
		logic signed [CW-1:0]     cy;
		logic [ANGLE_W-1:0]       z;
	} stage_t;

	function automatic logic [SAMPLE_W-1:0] sat_norm(input logic [QBITS-1:0] q,
		input logic ovf, input logic neg);
		logic [SAMPLE_W-1:0] r;
		if (neg) begin
			r = (ovf || (q > NORM_MIN)) ? NORM_MIN : SAMPLE_W'(-q);
		end else begin
			r = (ovf || (q > NORM_MAX)) ? NORM_MAX : q;
		end
		return r;
	endfunction

	logic [HW-1:0] held_q;
	stage_t        pipe_s [DEPTH+1];
	logic [DEPTH:0] v_s;
	stage_t        first_c;

	// results in flight or waiting; bounded by the output queue depth
	assign mid_pop = !mid_empty && (held_q < HW'(OUT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else begin
			held_q <= held_q + HW'(mid_pop) - HW'(res_pop);
		end
	end

	// entry stage: rounding numerator, overflow test, half-turn prerotation
	always_comb begin
		logic signed [CW-1:0] vx, vy;
		vx = {{(CW-VEC_W-VEC_SHIFT){mid_data.vec_x[VEC_W-1]}}, mid_data.vec_x,
			{VEC_SHIFT{1'b0}}};
		vy = {{(CW-VEC_W-VEC_SHIFT){mid_data.vec_y[VEC_W-1]}}, mid_data.vec_y,
			{VEC_SHIFT{1'b0}}};
		first_c.err   = mid_data.range_err;
		first_c.zero  = (mid_data.vec_x == '0) && (mid_data.vec_y == '0);
		first_c.neg_x = mid_data.neg_x;
		first_c.neg_y = mid_data.neg_y;
		first_c.rem_x = (RW'(mid_data.mag_x) << (FRAC_BITS+1)) + RW'(cal.span_x);
		first_c.rem_y = (RW'(mid_data.mag_y) << (FRAC_BITS+1)) + RW'(cal.span_y);
		first_c.ovf_x = DW'(first_c.rem_x) >= (DW'({cal.span_x, 1'b0}) << QBITS);
		first_c.ovf_y = DW'(first_c.rem_y) >= (DW'({cal.span_y, 1'b0}) << QBITS);
		first_c.q_x   = '0;
		first_c.q_y   = '0;
		if (vx < 0) begin
			first_c.cx = -vx;
			first_c.cy = -vy;
			first_c.z  = HALF_TURN;
		end else begin
			first_c.cx = vx;
			first_c.cy = vy;
			first_c.z  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= mid_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (mid_pop) begin
			pipe_s[0] <= first_c;
		end
	end

	// each stage: at most one quotient bit per axis and at most one rotation
	for (genvar j = 0; j < DEPTH; j++) begin : g_step
		localparam bit DO_DIV = (j < QBITS);
		localparam bit DO_ROT = (j < STEPS);
		localparam int K      = DO_DIV ? (QBITS - 1 - j) : 0;
		stage_t nxt;

		always_comb begin
			logic signed [CW-1:0] cx, cy;
			logic [DW-1:0]        dsh_x, dsh_y;
			nxt   = pipe_s[j];
			cx    = pipe_s[j].cx;
			cy    = pipe_s[j].cy;
			dsh_x = DW'({cal.span_x, 1'b0}) << K;
			dsh_y = DW'({cal.span_y, 1'b0}) << K;
			if (DO_DIV) begin
				if (DW'(pipe_s[j].rem_x) >= dsh_x) begin
					nxt.rem_x  = RW'(DW'(pipe_s[j].rem_x) - dsh_x);
					nxt.q_x[K] = 1'b1;
				end
				if (DW'(pipe_s[j].rem_y) >= dsh_y) begin
					nxt.rem_y  = RW'(DW'(pipe_s[j].rem_y) - dsh_y);
					nxt.q_y[K] = 1'b1;
				end
			end
			if (DO_ROT) begin
				if (!cy[CW-1]) begin
					nxt.cx = cx + (cy >>> j);
					nxt.cy = cy - (cx >>> j);
					nxt.z  = pipe_s[j].z + atan_angle(j);
				end else begin
					nxt.cx = cx - (cy >>> j);
					nxt.cy = cy + (cx >>> j);
					nxt.z  = pipe_s[j].z - atan_angle(j);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			pipe_s[j+1] <= nxt;
		end
	end

	// conversion: saturate quotients, scale angle to degrees
	logic                       v_conv_s1, v_conv_s2;
	logic                       err_conv_s1, zero_conv_s1;
	logic [SAMPLE_W-1:0]        xn_conv_s1, yn_conv_s1;
	logic signed [PROD_W-1:0]   prod_conv_s1;
	cch_out_t                   res_c, res_conv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_conv_s1 <= 1'b0;
			v_conv_s2 <= 1'b0;
		end else begin
			v_conv_s1 <= v_s[DEPTH];
			v_conv_s2 <= v_conv_s1;
		end
	end

	always_ff @(posedge clk) begin
		err_conv_s1  <= pipe_s[DEPTH].err;
		zero_conv_s1 <= pipe_s[DEPTH].zero;
		xn_conv_s1   <= sat_norm(pipe_s[DEPTH].q_x, pipe_s[DEPTH].ovf_x, pipe_s[DEPTH].neg_x);
		yn_conv_s1   <= sat_norm(pipe_s[DEPTH].q_y, pipe_s[DEPTH].ovf_y, pipe_s[DEPTH].neg_y);
		prod_conv_s1 <= $signed(pipe_s[DEPTH].z) * $signed(10'sd360);
		res_conv_s2  <= res_c;
	end

	always_comb begin
		logic [PROD_W-1:0] mag;
		logic [DEG_W-1:0]  t, deg;
		mag = prod_conv_s1[PROD_W-1] ? PROD_W'(-prod_conv_s1) : prod_conv_s1;
		t   = mag[ANGLE_W +: DEG_W];
		// truncate toward zero, then wrap negative angles
		if (prod_conv_s1[PROD_W-1] && (t != '0)) begin
			deg = FULL_DEG - t;
		end else begin
			deg = t;
		end
		res_c.range_error = err_conv_s1;
		res_c.x_norm      = err_conv_s1 ? '0 : xn_conv_s1;
		res_c.y_norm      = err_conv_s1 ? '0 : yn_conv_s1;
		res_c.heading_deg = (err_conv_s1 || zero_conv_s1) ? '0 : deg;
	end

	assign res_push = v_conv_s2;
	assign res_data = res_conv_s2;

	`CCH_ASSERT_HOLD(a_back_held_bound, held_q <= HW'(OUT_DEPTH))
	`CCH_ASSERT_IMPL(a_back_pop_held, res_pop, held_q != '0)
	`CCH_ASSERT_IMPL(a_back_pipe_origin, v_s[DEPTH], $past(mid_pop, DEPTH+1))
endmodule
`default_nettype wire

// File: hdl/compass_heading_with_calibration_unit.sv
// Path: front s1/s2, mid queue, entry stage, divider/CORDIC stages, conv_s1/s2,
//   result queue. Throughput while the output side does not stall:
//   one beat per cycle, set by the one-step-per-stage CORDIC/divider pipe.
// Reset: arst_n clears all calibration bounds to 0 and empties both queues;
//   no clearing pass, the block takes beats in the first cycle after reset.
`default_nettype none
module compass_heading_with_calibration_unit #(
	parameter int CORDIC_STEPS = 16,
	parameter int FRAC_BITS = 14
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [cch_pkg::REG_IDX_W-1:0]   wr_idx,
	input  logic [cch_pkg::SAMPLE_W-1:0]    wr_data,
	input  logic                            push,
	output logic                            full,
	input  cch_pkg::cch_in_t                item,
	output logic                            empty,
	input  logic                            pop,
	output cch_pkg::cch_out_t               result
);
	import cch_pkg::*;

	// output queue covers every beat in the back pipe plus one waiting
	localparam int OUT_DEPTH = 2 ** $clog2(pipe_len(CORDIC_STEPS) + 4);
	localparam int WORK_W    = $bits(cch_work_t);
	localparam int OUT_W     = $bits(cch_out_t);

	logic                mid_push, mid_pop, mid_empty;
	logic [MID_CW-1:0]   mid_count;
	cch_work_t           mid_in;
	logic [WORK_W-1:0]   mid_dout;
	cch_cal_t            cal;
	logic                res_push, res_pop;
	cch_out_t            res_data;
	logic [OUT_W-1:0]    out_dout;

	// front: config registers, centering and cross-scaling products
	cch_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_idx    (wr_idx),
		.wr_data   (wr_data),
		.push      (push),
		.item      (item),
		.full      (full),
		.mid_count (mid_count),
		.mid_push  (mid_push),
		.mid_data  (mid_in),
		.cal       (cal)
	);

	// short queue decoupling front from back
	cch_fifo #(
		.W     (WORK_W),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.din    (mid_in),
		.pop    (mid_pop),
		.dout   (mid_dout),
		.empty  (mid_empty),
		.count  (mid_count)
	);

	// back: restoring divider bits and vectoring CORDIC in lockstep
	cch_back #(
		.CORDIC_STEPS (CORDIC_STEPS),
		.FRAC_BITS    (FRAC_BITS),
		.OUT_DEPTH    (OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.mid_data  (cch_work_t'(mid_dout)),
		.mid_pop   (mid_pop),
		.cal       (cal),
		.res_pop   (res_pop),
		.res_push  (res_push),
		.res_data  (res_data)
	);

	assign res_pop = pop && !empty;

	// result queue; its credit is tracked in the back
	cch_fifo #(
		.W     (OUT_W),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (res_data),
		.pop    (res_pop),
		.dout   (out_dout),
		.empty  (empty),
		.count  ()
	);

	assign result = cch_out_t'(out_dout);
endmodule
`default_nettype wire

// File: test/compass_heading_with_calibration_unit_checker.sv
`default_nettype none
module compass_heading_with_calibration_unit_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [cch_pkg::REG_IDX_W-1:0] wr_idx,
	input  logic [cch_pkg::SAMPLE_W-1:0]  wr_data,
	input  logic                          push,
	input  logic                          full,
	input  cch_pkg::cch_in_t              item,
	input  logic                          empty,
	input  logic                          pop,
	input  cch_pkg::cch_out_t             result,
	output int                            fail_count,
	output int                            pending
);
	import cch_pkg::*;

	localparam int STEPS = 16;
	localparam int FBITS = 14;

	logic signed [15:0] bound_xu, bound_xl, bound_yu, bound_yl;
	cch_out_t heading_q[$];

	function automatic logic [31:0] atan_step(input int i);
		logic [31:0] t[24];
		t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
			32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
			32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
			32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
			32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
		return t[i];
	endfunction

	// rounded to nearest, ties away from zero, saturated
	function automatic logic [15:0] scale_axis(input longint num, input longint den);
		logic neg;
		longint an, ad, q;
		neg = (num < 0) != (den < 0);
		an = num < 0 ? -num : num;
		ad = den < 0 ? -den : den;
		q = (an * (64'sd1 << FBITS) + ad / 2) / ad;
		if (!neg) return q > 32767 ? 16'sh7FFF : q[15:0];
		return q > 32768 ? 16'sh8000 : 16'(-q);
	endfunction

	// >>> on signed longint is arithmetic, i.e. a floor shift
	function automatic logic [8:0] bearing(input longint vx, input longint vy);
		logic [31:0] z;
		longint tx, ty, a, deg;
		int n;
		z = '0;
		if (vx == 0 && vy == 0) return '0;
		vx = vx <<< 20;
		vy = vy <<< 20;
		if (vx < 0) begin
			vx = -vx;
			vy = -vy;
			z = 32'h8000_0000;
		end
		n = STEPS < 24 ? STEPS : 24;
		for (int i = 0; i < n; i++) begin
			if (vy >= 0) begin
				tx = vx + (vy >>> i);
				ty = vy - (vx >>> i);
				z += atan_step(i);
			end else begin
				tx = vx - (vy >>> i);
				ty = vy + (vx >>> i);
				z -= atan_step(i);
			end
			vx = tx;
			vy = ty;
		end
		a = longint'(signed'(z));
		deg = (a * 360) / (64'sd1 <<< 32);
		if (deg < 0) deg += 360;
		return deg[8:0];
	endfunction

	function automatic cch_out_t predict(input cch_in_t s);
		cch_out_t r;
		longint dx, dy, nx, ny, vx, vy;
		r = '0;
		dx = longint'(bound_xu) - bound_xl;
		dy = longint'(bound_yu) - bound_yl;
		if (dx == 0 || dy == 0) begin
			r.range_error = 1'b1;
			return r;
		end
		nx = 2 * longint'(s.x_sample) - bound_xu - bound_xl;
		ny = 2 * longint'(s.y_sample) - bound_yu - bound_yl;
		r.x_norm = scale_axis(nx, dx);
		r.y_norm = scale_axis(ny, dy);
		vx = nx * (dy < 0 ? -dy : dy) * (dx < 0 ? -1 : 1);
		vy = ny * (dx < 0 ? -dx : dx) * (dy < 0 ? -1 : 1);
		r.heading_deg = bearing(vx, vy);
		return r;
	endfunction

	assign pending = heading_q.size();

	always @(posedge clk or negedge arst_n) begin
		cch_out_t want;
		if (!arst_n) begin
			bound_xu <= '0;
			bound_xl <= '0;
			bound_yu <= '0;
			bound_yl <= '0;
			fail_count <= 0;
			heading_q.delete();
		end else begin
			if (push && !full) heading_q.push_back(predict(item));
			if (pop && !empty) begin
				if (heading_q.size() == 0) begin
					if (fail_count < 10) $display("unexpected beat %h", result);
					fail_count <= fail_count + 1;
				end else begin
					want = heading_q.pop_front();
					if (want !== result) begin
						if (fail_count < 10)
							$display("mismatch: exp xn=%0d yn=%0d hd=%0d err=%0b got xn=%0d yn=%0d hd=%0d err=%0b",
								want.x_norm, want.y_norm, want.heading_deg, want.range_error,
								result.x_norm, result.y_norm, result.heading_deg,
								result.range_error);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (wr_en) begin
				case (wr_idx)
					REG_X_UPPER: bound_xu <= wr_data;
					REG_X_LOWER: bound_xl <= wr_data;
					REG_Y_UPPER: bound_yu <= wr_data;
					REG_Y_LOWER: bound_yl <= wr_data;
					default: ;
				endcase
			end
		end
	end
endmodule
`default_nettype wire

// File: test/compass_heading_with_calibration_unit_test.sv
`default_nettype none
module compass_heading_with_calibration_unit_test;
	import cch_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [REG_IDX_W-1:0] wr_idx = '0;
	logic [SAMPLE_W-1:0] wr_data = '0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty;
	cch_in_t item = '0;
	cch_out_t result;
	int fail_count, pending;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	compass_heading_with_calibration_unit dut (
		.clk, .arst_n, .wr_en, .wr_idx, .wr_data,
		.push, .full, .item, .empty, .pop, .result
	);

	compass_heading_with_calibration_unit_checker chk (
		.clk, .arst_n, .wr_en, .wr_idx, .wr_data,
		.push, .full, .item, .empty, .pop, .result,
		.fail_count, .pending
	);

	// receiver: stall pattern switches mode every so often, incl. no-stall stretches
	int stall_mode = 0;
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: pop <= 1'b1;
			1: pop <= $urandom_range(0, 3) != 0;
			2: pop <= 1'($urandom_range(0, 1));
			default: pop <= $urandom_range(0, 7) == 0;
		endcase
	end

	// one beat; push stays high across back-to-back beats
	task automatic send_beat(input logic [15:0] xs, input logic [15:0] ys, input bit hold);
		push <= 1'b1;
		item <= '{x_sample: xs, y_sample: ys};
		@(posedge clk);
		while (full) @(posedge clk);
		if (!hold) push <= 1'b0;
	endtask

	// bursts with random gaps between them
	task automatic send_burst(input logic [15:0] xs[$], input logic [15:0] ys[$]);
		int left;
		left = 0;
		foreach (xs[i]) begin
			if (left == 0) begin
				repeat ($urandom_range(1, 6)) @(posedge clk);
				left = $urandom_range(1, 20);
			end
			left--;
			send_beat(xs[i], ys[i], left != 0 && i != xs.size() - 1);
		end
		// let the checker record the last beat before anyone reads pending
		@(posedge clk);
	endtask

	// drain, then let the pipe settle before touching the bounds
	task automatic quiesce();
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic set_bounds(input logic [15:0] xu, xl, yu, yl);
		logic [15:0] v[4];
		v = '{xu, xl, yu, yl};
		for (int i = 0; i < 4; i++) begin
			wr_en <= 1'b1;
			wr_idx <= REG_IDX_W'(i);
			wr_data <= v[i];
			@(posedge clk);
		end
		wr_en <= 1'b0;
	endtask

	function automatic logic [15:0] rand_near(input logic signed [15:0] lo,
			input logic signed [15:0] hi);
		int a, b;
		a = lo < hi ? lo : hi;
		b = lo < hi ? hi : lo;
		if ($urandom_range(0, 9) == 0) return 16'($urandom);
		return 16'($urandom_range(0, b - a + 2) + a - 1);
	endfunction

	initial begin
		logic [15:0] xs[$], ys[$];
		logic [15:0] xu, xl, yu, yl;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset bounds are equal: error path
		xs = '{16'h7FFF, 16'h8000};
		ys = '{16'h8000, 16'h7FFF};
		send_burst(xs, ys);
		quiesce();

		// widest span, then directed extremes
		set_bounds(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
		xs = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h4000,
			16'h0000, 16'hFFFF, 16'h0001};
		ys = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'hC000,
			16'h7FFF, 16'h0000, 16'hFFFF};
		send_burst(xs, ys);
		quiesce();

		// narrow span: saturation both ways; reversed bounds
		set_bounds(16'd1, 16'd0, 16'hFFFF, 16'd0);
		xs = '{16'h7FFF, 16'h8000, 16'd0, 16'd1, 16'h0000};
		ys = '{16'h8000, 16'h7FFF, 16'd0, 16'hFFFF, 16'h7FFF};
		send_burst(xs, ys);
		quiesce();

		// only one axis degenerate
		set_bounds(16'd100, 16'hFF9C, 16'd5, 16'd5);
		xs = '{16'd50, 16'h8000};
		ys = '{16'd5, 16'd7};
		send_burst(xs, ys);
		quiesce();

		// random phases, each with its own bounds; samples mostly near the span
		for (int ph = 0; ph < 13; ph++) begin
			xu = 16'($urandom); xl = 16'($urandom);
			yu = 16'($urandom); yl = 16'($urandom);
			if (ph % 4 == 1) begin
				xu = 16'($urandom_range(0, 600)); xl = 16'(-$urandom_range(0, 600));
				yu = 16'($urandom_range(0, 600)); yl = 16'(-$urandom_range(0, 600));
			end
			if (ph == 7) yu = yl;
			if (ph == 11) begin
				xu = 16'h8000; xl = 16'h7FFF;
			end
			set_bounds(xu, xl, yu, yl);
			xs.delete();
			ys.delete();
			for (int k = 0; k < 100; k++) begin
				xs.push_back(rand_near(xu, xl));
				ys.push_back(rand_near(yu, yl));
			end
			send_burst(xs, ys);
			if (ph == 5) quiesce();
			else while (pending != 0) @(posedge clk);
			repeat (30) @(posedge clk);
		end

		quiesce();
		if (fail_count == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
`default_nettype wire

// File: compass_heading_with_calibration_unit.f
+incdir+hdl
hdl/cch_pkg.sv
hdl/cch_fifo.sv
hdl/cch_front.sv
hdl/cch_back.sv
hdl/compass_heading_with_calibration_unit.sv
test/compass_heading_with_calibration_unit_checker.sv
test/compass_heading_with_calibration_unit_test.sv
